>>> src/ordered_array_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// ordered array insert/delete assertion macros
// shared property wrappers for the controller and datapath checks
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define OAID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define OAID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/oaid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaid_pkg
// shared types, codes and widths of the ordered array insert/delete block
// ----------------------------------------------------------------------------
package oaid_pkg;

	localparam int unsigned CAPACITY_DEFAULT = 128;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_DEL_POS = 3'd2,
		CMD_DEL_VAL = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// memory read address select
	typedef enum logic [1:0] {
		RA_IDX,
		RA_IDX_DN,
		RA_IDX_UP,
		RA_POS
	} rd_sel_t;

	// walk index update
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POS,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS,
		S_INS_WR,
		S_DEL,
		S_DEL_WR,
		S_SRCH,
		S_SCMP,
		S_RCAP,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    latch;
		logic    set_status;
		logic    set_notfound;
		logic    set_found;
		logic    set_read;
		logic    wr_en;
		logic    wa_cnt;
		logic    wd_rd;
		logic    rd_en;
		rd_sel_t rd_at;
		idx_op_t idx_op;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_load;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic pre_ok;
		logic idx_at_pos;
		logic idx_last;
		logic idx_end;
		logic match;
		logic out_free;
	} dp_sts_t;

endpackage

>>> src/oaid_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaid request and response interfaces
// valid/ready channels carrying commands in and results out
// ----------------------------------------------------------------------------
interface oaid_req_if;
	import oaid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output command, output position, output value,
		input ready);
	modport sink (input valid, input command, input position, input value,
		output ready);
endinterface

interface oaid_rsp_if;
	import oaid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic [CNT_W-1:0]        entry_count;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0]        found_index;

	modport source (output valid, output status, output entry_count,
		output read_value, output found_index, input ready);
	modport sink (input valid, input status, input entry_count,
		input read_value, input found_index, output ready);
endinterface

>>> src/ordered_array_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_delete
// ordered list of signed 32-bit entries with append, insert, delete and read
// ----------------------------------------------------------------------------
// usage
//   req carries one command per transaction: command, position, value
//   rsp returns one result per command: status, entry_count, read_value,
//   found_index; both channels move a transaction when valid and ready are high
// sequencing
//   one command is worked at a time; req is ready only while the sequencer idles
//   append, spare codes and failed checks go from the check straight to the
//   result; read captures the entry at p; insert at p with n entries moves
//   entries n-1 down to p up by one, then writes the value at p; delete at p
//   moves the entries above p down by one; delete by value walks up from index
//   0 to the first hit at h and deletes there, or reports not found
//   the next command is taken in the idle state that follows the result load
//   every entry move is a memory read then a write through the single
//   read/write port pair
// reset
//   count clears to zero, sequencer idles, result register empties;
//   the entry memory is not cleared, only entries below count are ever read
// stall
//   a finished result waits in the result register; the next command is
//   still accepted and is worked up to its own result, which waits for rsp
// ----------------------------------------------------------------------------
module ordered_array_insert_delete #(
	parameter int unsigned CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	oaid_req_if.sink   req,
	oaid_rsp_if.source rsp
);
	import oaid_pkg::*;

	// command and status bundles between sequencer and datapath
	dp_ctl_t ctl;
	dp_sts_t sts;
	logic    req_ready;

	assign req.ready = req_ready;

	// sequencer: decides each step of the current transaction
	oaid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// datapath: entry memory, count, walk index and result register
	oaid_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (req.command),
		.position    (req.position),
		.value       (req.value),
		.ctl         (ctl),
		.sts         (sts),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.status      (rsp.status),
		.entry_count (rsp.entry_count),
		.read_value  (rsp.read_value),
		.found_index (rsp.found_index)
	);

endmodule

>>> src/oaid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaid_ctrl
// command sequencer: checks, search walk, shift walks and result hand-off
// ----------------------------------------------------------------------------
`include "ordered_array_insert_delete_assert.svh"

module oaid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  oaid_pkg::dp_sts_t sts,
	output oaid_pkg::dp_ctl_t ctl
);
	import oaid_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.pre_ok) begin
					state_nx = S_DONE;
				end else begin
					unique case (sts.cmd)
						CMD_INSERT:  state_nx = S_INS;
						CMD_DEL_POS: state_nx = S_DEL;
						CMD_DEL_VAL: state_nx = S_SRCH;
						CMD_READ:    state_nx = S_RCAP;
						default:     state_nx = S_DONE;
					endcase
				end
			end
			S_INS:    state_nx = sts.idx_at_pos ? S_DONE : S_INS_WR;
			S_INS_WR: state_nx = S_INS;
			S_DEL:    state_nx = sts.idx_last ? S_DONE : S_DEL_WR;
			S_DEL_WR: state_nx = S_DEL;
			S_SRCH:   state_nx = sts.idx_end ? S_DONE : S_SCMP;
			S_SCMP:   state_nx = sts.match ? S_DEL : S_SRCH;
			S_RCAP:   state_nx = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default:  state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				ctl.latch = req_valid;
			end
			S_CHECK: begin
				ctl.set_status = 1'b1;
				if (sts.pre_ok) begin
					unique case (sts.cmd)
						CMD_APPEND: begin
							ctl.wr_en   = 1'b1;
							ctl.wa_cnt  = 1'b1;
							ctl.cnt_inc = 1'b1;
						end
						CMD_INSERT:  ctl.idx_op = IDX_COUNT;
						CMD_DEL_POS: ctl.idx_op = IDX_POS;
						CMD_DEL_VAL: ctl.idx_op = IDX_ZERO;
						CMD_READ: begin
							ctl.rd_en = 1'b1;
							ctl.rd_at = RA_POS;
						end
						default: ;
					endcase
				end
			end
			S_INS: begin
				if (sts.idx_at_pos) begin
					ctl.wr_en   = 1'b1;
					ctl.cnt_inc = 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_at = RA_IDX_DN;
				end
			end
			S_INS_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wd_rd  = 1'b1;
				ctl.idx_op = IDX_DEC;
			end
			S_DEL: begin
				if (sts.idx_last) begin
					ctl.cnt_dec = 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_at = RA_IDX_UP;
				end
			end
			S_DEL_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wd_rd  = 1'b1;
				ctl.idx_op = IDX_INC;
			end
			S_SRCH: begin
				if (sts.idx_end) begin
					ctl.set_notfound = 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_at = RA_IDX;
				end
			end
			S_SCMP: begin
				if (sts.match) begin
					ctl.set_found = 1'b1;
				end else begin
					ctl.idx_op = IDX_INC;
				end
			end
			S_RCAP: ctl.set_read = 1'b1;
			S_DONE: ctl.out_load = sts.out_free;
			default: ;
		endcase
	end

	`OAID_ASSERT_IMP(a_no_rd_wr_same_cycle, clk, arst_n, 1'b1, !(ctl.wr_en && ctl.rd_en), "memory read and write issued in the same cycle")
	`OAID_ASSERT_NXT(a_fail_goes_done, clk, arst_n, state_q == S_CHECK && !sts.pre_ok, state_q == S_DONE, "failed check did not go straight to result")
	`OAID_ASSERT_NXT(a_count_edit_last, clk, arst_n, ctl.cnt_inc || ctl.cnt_dec, state_q == S_DONE, "count changed before the last step of a command")

endmodule

>>> src/oaid_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaid_dpath
// entry memory, count, walk index, checks and result register
// ----------------------------------------------------------------------------
`include "ordered_array_insert_delete_assert.svh"

module oaid_dpath #(
	parameter int unsigned CAPACITY = oaid_pkg::CAPACITY_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [oaid_pkg::CMD_W-1:0]       command,
	input  logic [oaid_pkg::POS_W-1:0]       position,
	input  logic signed [oaid_pkg::VAL_W-1:0] value,
	input  oaid_pkg::dp_ctl_t                ctl,
	output oaid_pkg::dp_sts_t                sts,
	input  logic                             rsp_ready,
	output logic                             rsp_valid,
	output logic [oaid_pkg::STAT_W-1:0]      status,
	output logic [oaid_pkg::CNT_W-1:0]       entry_count,
	output logic signed [oaid_pkg::VAL_W-1:0] read_value,
	output logic [oaid_pkg::POS_W-1:0]       found_index
);
	import oaid_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam int EW = (CW > CNT_W) ? CW : CNT_W;

	cmd_t                    cmd_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] rd_val_q;
	logic [POS_W-1:0]        found_q;

	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic signed [VAL_W-1:0] mem_rd_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [CNT_W-1:0]        out_count_q;
	logic signed [VAL_W-1:0] out_read_q;
	logic [POS_W-1:0]        out_found_q;

	logic [XW-1:0]           pos_x;
	logic [XW-1:0]           cnt_x;
	logic [XW-1:0]           idx_x;
	logic [EW-1:0]           cnt_e;
	logic [CW-1:0]           idx_up;
	logic [CW-1:0]           idx_dn;
	logic                    full;
	logic                    empty;
	status_t                 pre_status;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign idx_x  = XW'(idx_q);
	assign cnt_e  = EW'(count_q);
	assign idx_up = idx_q + 1'b1;
	assign idx_dn = idx_q - 1'b1;
	assign full   = count_q >= CW'(CAPACITY);
	assign empty  = count_q == '0;

	// command checks against the current fill
	always_comb begin
		pre_status = ST_OK;
		unique case (cmd_q)
			CMD_APPEND: begin
				if (full) pre_status = ST_FULL;
			end
			CMD_INSERT: begin
				if (full)               pre_status = ST_FULL;
				else if (pos_x > cnt_x) pre_status = ST_BADPOS;
			end
			CMD_DEL_POS, CMD_READ: begin
				if (empty)               pre_status = ST_EMPTY;
				else if (pos_x >= cnt_x) pre_status = ST_BADPOS;
			end
			CMD_DEL_VAL: begin
				if (empty) pre_status = ST_EMPTY;
			end
			default: pre_status = ST_OK;
		endcase
	end

	always_comb begin
		case (ctl.rd_at)
			RA_IDX:    rd_addr = idx_q[AW-1:0];
			RA_IDX_DN: rd_addr = idx_dn[AW-1:0];
			RA_IDX_UP: rd_addr = idx_up[AW-1:0];
			default:   rd_addr = pos_x[AW-1:0];
		endcase
	end

	assign wr_addr = ctl.wa_cnt ? count_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = ctl.wd_rd ? mem_rd_q : val_q;

	assign sts.cmd        = cmd_q;
	assign sts.pre_ok     = pre_status == ST_OK;
	assign sts.idx_at_pos = idx_x == pos_x;
	assign sts.idx_last   = idx_up >= count_q;
	assign sts.idx_end    = idx_q >= count_q;
	assign sts.match      = mem_rd_q == val_q;
	assign sts.out_free   = !out_valid_q || rsp_ready;

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) mem[wr_addr] <= wr_data;
		if (ctl.rd_en) mem_rd_q <= mem[rd_addr];
	end

	// operands and working result
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd_t'(command);
			pos_q <= position;
			val_q <= value;
		end
		if (ctl.set_status)        status_q <= pre_status;
		else if (ctl.set_notfound) status_q <= ST_NOTFOUND;
		if (ctl.latch)         rd_val_q <= '0;
		else if (ctl.set_read) rd_val_q <= mem_rd_q;
		if (ctl.latch)          found_q <= '0;
		else if (ctl.set_found) found_q <= idx_x[POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (ctl.idx_op)
			IDX_COUNT: idx_q <= count_q;
			IDX_POS:   idx_q <= pos_x[CW-1:0];
			IDX_ZERO:  idx_q <= '0;
			IDX_INC:   idx_q <= idx_up;
			IDX_DEC:   idx_q <= idx_dn;
			default:   idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= status_q;
			out_count_q  <= cnt_e[CNT_W-1:0];
			out_read_q   <= rd_val_q;
			out_found_q  <= found_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign read_value  = out_read_q;
	assign found_index = out_found_q;

	`OAID_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`OAID_ASSERT_IMP(a_fail_zero_fields, clk, arst_n, out_valid_q && out_status_q != ST_OK, out_read_q == '0 && out_found_q == '0, "failed result carries nonzero data")
	`OAID_ASSERT_NXT(a_count_step, clk, arst_n, ctl.cnt_inc, count_q == CW'($past(count_q) + 1'b1), "count did not advance by one")

endmodule
